>>> design/slam_pkg.sv
`timescale 1ns / 1ps

package slam_pkg;

    // Default sizes: table and sample widths for the top level, depth of both queues
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int QUEUE_DEPTH         = 2;

    // Register field widths
    localparam int GAIN_W     = 23;
    localparam int WAVE_W     = 3;
    localparam int AMT_W      = 17;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int LFO_W      = 18;   // signed Q.16 LFO value and gain, -1.0 .. 1.0

    // Phase positions in Q.32 cycles, 40 bits wide
    localparam logic [39:0] P_CYCLE = 40'h01_0000_0000;
    localparam logic [39:0] P_LIMIT = 40'd100 << 32;

    // Sine series constants, Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_GAIN  = 4'd0,
        CFG_OUTPUT_GAIN = 4'd1,
        CFG_WAVEFORM    = 4'd2,
        CFG_MOD_AMOUNT  = 4'd3,
        CFG_OFFSET_L    = 4'd4,
        CFG_OFFSET_R    = 4'd5,
        CFG_WIDTH_RECIP = 4'd6,
        CFG_PHASE_STEP  = 4'd7
    } t_cfg_idx;

    // LFO shapes
    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_SAW_UP   = 3'd3,
        WAVE_SAW_DOWN = 3'd4
    } t_wave;

    // Back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_LFO,
        ST_GAIN,
        ST_MUL_B,
        ST_MUL_C,
        ST_SAT
    } t_back_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  input_gain;
        logic [GAIN_W-1:0]  output_gain;
        logic [WAVE_W-1:0]  waveform;
        logic [AMT_W-1:0]   mod_amount;
        logic [AMT_W-1:0]   offset_left;
        logic [AMT_W-1:0]   offset_right;
        logic [GAIN_W-1:0]  width_recip;
        logic [PHASE_W-1:0] phase_step;
    } t_slam_cfg;

    // round(2^16 * sin(pi/2 * r / quarter)), quarter = 2^(bits-2); table build only
    function automatic logic [16:0] sine_quarter(input logic [31:0] r, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (HALF_PI_Q30 * ({32'b0, r} << 2)) >> bits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return s[16:0];
    endfunction

endpackage

>>> design/stereo_lfo_amplitude_modulator_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake                  | Beat contents
// ----------+----------------------------+------------------------------------------
// input     | push / full                | i_left_sample, i_right_sample
// result    | pop / empty                | o_left_result, o_right_result
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// In the back end a stereo pair takes the phase multiply, then per channel WRAP, LFO,
// GAIN, MUL_B, MUL_C and SAT; all multiplies share one multiplier, which sets the rate.
// Input and result queues are two beats deep; a full result queue holds the back end
// in its last step while the input queue keeps taking beats.
// Synchronous reset clears LFO phase and queues, loads config defaults; no clearing pass.
// The configuration port is always ready.

module stereo_lfo_amplitude_modulator_core #(
    parameter int SINE_TABLE_BITS = slam_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = slam_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [SAMPLE_BITS-1:0]       i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       i_right_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [SAMPLE_BITS-1:0]       o_left_result,
    output logic signed [SAMPLE_BITS-1:0]       o_right_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slam_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    slam_pkg::t_slam_cfg          r_cfg;
    logic                         w_in_valid;
    logic                         w_in_pop;
    logic [slam_pkg::PHASE_W-1:0] w_in_phase;
    logic signed [SAMPLE_BITS-1:0] w_in_left;
    logic signed [SAMPLE_BITS-1:0] w_in_right;
    logic                         w_out_push;
    logic                         w_out_full;
    logic signed [SAMPLE_BITS-1:0] w_out_left;
    logic signed [SAMPLE_BITS-1:0] w_out_right;
    logic [2*SAMPLE_BITS-1:0]     w_out_q_in;
    logic [2*SAMPLE_BITS-1:0]     w_out_q_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain   <= 23'd65536;
            r_cfg.output_gain  <= 23'd65536;
            r_cfg.waveform     <= slam_pkg::WAVE_SINE;
            r_cfg.mod_amount   <= 17'd65536;
            r_cfg.offset_left  <= 17'd0;
            r_cfg.offset_right <= 17'd32768;
            r_cfg.width_recip  <= 23'd65536;
            r_cfg.phase_step   <= 32'd89478;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                slam_pkg::CFG_INPUT_GAIN:  r_cfg.input_gain   <= i_cfg_data[22:0];
                slam_pkg::CFG_OUTPUT_GAIN: r_cfg.output_gain  <= i_cfg_data[22:0];
                slam_pkg::CFG_WAVEFORM:    r_cfg.waveform     <= i_cfg_data[2:0];
                slam_pkg::CFG_MOD_AMOUNT:  r_cfg.mod_amount   <= i_cfg_data[16:0];
                slam_pkg::CFG_OFFSET_L:    r_cfg.offset_left  <= i_cfg_data[16:0];
                slam_pkg::CFG_OFFSET_R:    r_cfg.offset_right <= i_cfg_data[16:0];
                slam_pkg::CFG_WIDTH_RECIP: r_cfg.width_recip  <= i_cfg_data[22:0];
                slam_pkg::CFG_PHASE_STEP:  r_cfg.phase_step   <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // front: input queue and phase tagging
    slam_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_left       (i_left_sample),
        .i_right      (i_right_sample),
        .i_phase_step (r_cfg.phase_step),
        .o_full       (full),
        .i_pop        (w_in_pop),
        .o_valid      (w_in_valid),
        .o_phase      (w_in_phase),
        .o_left       (w_in_left),
        .o_right      (w_in_right)
    );

    // back: LFO and gain chain
    slam_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (w_in_valid),
        .i_in_phase  (w_in_phase),
        .i_in_left   (w_in_left),
        .i_in_right  (w_in_right),
        .o_in_pop    (w_in_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out_left  (w_out_left),
        .o_out_right (w_out_right)
    );

    // result queue
    assign w_out_q_in = {w_out_left, w_out_right};

    slam_fifo #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (slam_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_q_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_q_out),
        .o_empty (empty)
    );

    assign o_left_result  = w_out_q_out[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign o_right_result = w_out_q_out[SAMPLE_BITS-1:0];

`ifndef ASSERT_OFF
    // the back end only writes a result when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result written into a full queue");

    // the back end only takes a beat that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_pop |-> w_in_valid)
        else $error("input beat taken from an empty queue");

    // one result per pair: a write is never followed straight by another
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |=> !w_out_push)
        else $error("two results written on consecutive cycles");
`endif

endmodule

>>> design/slam_fifo.sv
`timescale 1ns / 1ps

module slam_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = slam_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/slam_front.sv
`timescale 1ns / 1ps

module slam_front #(
    parameter int SAMPLE_BITS = slam_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH       = slam_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic signed [SAMPLE_BITS-1:0]     i_left,
    input  logic signed [SAMPLE_BITS-1:0]     i_right,
    input  logic [slam_pkg::PHASE_W-1:0]      i_phase_step,
    output logic                              o_full,
    input  logic                              i_pop,
    output logic                              o_valid,
    output logic [slam_pkg::PHASE_W-1:0]      o_phase,
    output logic signed [SAMPLE_BITS-1:0]     o_left,
    output logic signed [SAMPLE_BITS-1:0]     o_right
);

    localparam int QW = slam_pkg::PHASE_W + 2 * SAMPLE_BITS;

    logic [slam_pkg::PHASE_W-1:0] r_phase;
    logic [QW-1:0]                w_q_in;
    logic [QW-1:0]                w_q_out;
    logic                         w_empty;

    // each accepted beat is tagged with the current LFO phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_push && !o_full) begin
            r_phase <= r_phase + i_phase_step;
        end
    end

    assign w_q_in = {r_phase, i_left, i_right};

    slam_fifo #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_q_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign o_valid = !w_empty;
    assign o_phase = w_q_out[QW-1 -: slam_pkg::PHASE_W];
    assign o_left  = w_q_out[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign o_right = w_q_out[SAMPLE_BITS-1:0];

endmodule

>>> design/slam_back.sv
`timescale 1ns / 1ps

module slam_back #(
    parameter int SINE_TABLE_BITS = slam_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = slam_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slam_pkg::t_slam_cfg           i_cfg,
    input  logic                          i_in_valid,
    input  logic [slam_pkg::PHASE_W-1:0]  i_in_phase,
    input  logic signed [SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS-1:0] i_in_right,
    output logic                          o_in_pop,
    input  logic                          i_out_full,
    output logic                          o_out_push,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right
);

    localparam int B       = SINE_TABLE_BITS;
    localparam int S       = SAMPLE_BITS;
    localparam int QUARTER = 1 << (B - 2);
    localparam int IDX_W   = B - 1;
    localparam int A_W     = S + 7;       // input after input gain
    localparam int BB_W    = S + 9;       // after LFO gain
    localparam int C_W     = S + 16;      // after output gain, before clamping
    localparam int MA      = (S + 9 > 33) ? S + 9 : 33;
    localparam int MB      = 24;
    localparam int PW      = MA + MB;
    localparam int LW      = slam_pkg::LFO_W;
    localparam int AMT_W_L = slam_pkg::AMT_W;
    localparam logic signed [C_W-1:0] SAT_MAX = C_W'((longint'(1) <<< (S - 1)) - 1);
    localparam logic signed [C_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [35:0] C30   = 36'sh0_4000_0000;
    localparam logic signed [35:0] C30X3 = 36'sh0_C000_0000;
    localparam logic signed [35:0] C31   = 36'sh0_8000_0000;
    localparam logic signed [35:0] C32   = 36'sh1_0000_0000;
    localparam logic signed [35:0] C33   = 36'sh2_0000_0000;

    slam_pkg::t_back_state r_state, n_state;
    logic                  r_ch, n_ch;

    logic signed [S-1:0]     r_x_l;
    logic signed [S-1:0]     r_x_r;
    logic signed [PW-1:0]    r_prod;
    logic [38:0]             r_pbase;
    logic [32:0]             r_p;
    logic [16:0]             r_sin;
    logic signed [A_W-1:0]   r_a;
    logic signed [LW-1:0]    r_g;
    logic signed [S-1:0]     r_res_l;

    logic                    w_mul_en;
    logic signed [MA-1:0]    w_mul_a;
    logic signed [MB-1:0]    w_mul_b;
    logic                    w_in_pop;
    logic                    w_out_push;
    logic signed [S-1:0]     w_x;
    logic signed [BB_W-1:0]  w_b;
    logic signed [C_W-1:0]   w_c;
    logic signed [S-1:0]     w_sat;
    logic [38:0]             w_pbase;
    logic [AMT_W_L-1:0]      w_offset;
    logic [39:0]             w_psum;
    logic [39:0]             w_pclamp;
    logic [32:0]             w_pwrap;
    logic [IDX_W-1:0]        w_rom_idx;
    logic [16:0]             w_rom [QUARTER + 1];
    logic signed [35:0]      w_ps;
    logic signed [35:0]      w_v32;
    logic signed [LW-1:0]    w_sine;
    logic signed [LW-1:0]    w_v;
    logic signed [35:0]      w_vm;
    logic signed [35:0]      w_g33;

    // quarter-wave sine table, built at elaboration
    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
        assign w_rom[gi] = slam_pkg::sine_quarter(32'(gi), B);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slam_pkg::ST_IDLE;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // sequencer: next state and multiplier operand selection
    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        w_in_pop   = 1'b0;
        w_out_push = 1'b0;
        w_mul_en   = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            slam_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    w_in_pop = 1'b1;
                    w_mul_en = 1'b1;
                    w_mul_a  = MA'({1'b0, i_in_phase});
                    w_mul_b  = {1'b0, i_cfg.width_recip};
                    n_ch     = 1'b0;
                    n_state  = slam_pkg::ST_WRAP;
                end
            end
            slam_pkg::ST_WRAP: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(w_x);
                w_mul_b  = {1'b0, i_cfg.input_gain};
                n_state  = slam_pkg::ST_LFO;
            end
            slam_pkg::ST_LFO: begin
                n_state = slam_pkg::ST_GAIN;
            end
            slam_pkg::ST_GAIN: begin
                n_state = slam_pkg::ST_MUL_B;
            end
            slam_pkg::ST_MUL_B: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(r_a);
                w_mul_b  = MB'(r_g);
                n_state  = slam_pkg::ST_MUL_C;
            end
            slam_pkg::ST_MUL_C: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA'(w_b);
                w_mul_b  = {1'b0, i_cfg.output_gain};
                n_state  = slam_pkg::ST_SAT;
            end
            slam_pkg::ST_SAT: begin
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = slam_pkg::ST_WRAP;
                end else if (!i_out_full) begin
                    w_out_push = 1'b1;
                    n_state    = slam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slam_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_pop   = w_in_pop;
    assign o_out_push = w_out_push;

    // channel operands
    assign w_x      = r_ch ? r_x_r : r_x_l;
    assign w_offset = r_ch ? i_cfg.offset_right : i_cfg.offset_left;
    assign w_b      = r_prod[16 +: BB_W];
    assign w_c      = r_prod[16 +: C_W];

    // stretched phase plus offset, clamped to P_LIMIT, then folded into a single LFO period
    assign w_pbase  = r_ch ? r_pbase : r_prod[16 +: 39];
    assign w_psum   = {1'b0, w_pbase} + 40'({w_offset, 16'b0});
    assign w_pclamp = (w_psum > slam_pkg::P_LIMIT) ? slam_pkg::P_LIMIT : w_psum;
    assign w_pwrap  = (w_pclamp > slam_pkg::P_CYCLE) ? {1'b0, w_pclamp[31:0]}
                                                     : w_pclamp[32:0];

    // table address: mirror the odd quadrants
    assign w_rom_idx = r_p[30] ? (IDX_W'(QUARTER) - {1'b0, r_p[29 -: B-2]})
                               : {1'b0, r_p[29 -: B-2]};

    // LFO value
    assign w_ps   = $signed({3'b0, r_p});
    assign w_sine = r_p[31] ? -$signed({1'b0, r_sin}) : $signed({1'b0, r_sin});

    always_comb begin
        w_v32 = '0;
        w_v   = '0;
        case (i_cfg.waveform)
            slam_pkg::WAVE_SINE: begin
                w_v = w_sine;
            end
            slam_pkg::WAVE_TRIANGLE: begin
                if (w_ps > C30X3) begin
                    w_v32 = ((w_ps - C30X3) <<< 2) - C32;
                end else if (w_ps > C30) begin
                    w_v32 = C33 - (w_ps <<< 2);
                end else begin
                    w_v32 = w_ps <<< 2;
                end
                w_v = w_v32[16 +: LW];
            end
            slam_pkg::WAVE_SQUARE: begin
                w_v32 = (w_ps < C31) ? -C32 : C32;
                w_v   = w_v32[16 +: LW];
            end
            slam_pkg::WAVE_SAW_UP: begin
                w_v32 = (w_ps <<< 1) - C32;
                w_v   = w_v32[16 +: LW];
            end
            slam_pkg::WAVE_SAW_DOWN: begin
                w_v32 = C32 - (w_ps <<< 1);
                w_v   = w_v32[16 +: LW];
            end
            default: begin
                w_v = '0;
            end
        endcase
    end

    // gain = 1 + (lfo*amount - amount)/2, Q.16
    assign w_vm  = w_v * $signed({1'b0, i_cfg.mod_amount});
    assign w_g33 = C33 + w_vm - $signed(36'({i_cfg.mod_amount, 16'b0}));

    // clamp to the sample range
    assign w_sat = (w_c > SAT_MAX) ? SAT_MAX[S-1:0] :
                   (w_c < SAT_MIN) ? SAT_MIN[S-1:0] : w_c[S-1:0];

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
    end

    // table read
    always_ff @(posedge i_clk) begin
        r_sin <= w_rom[w_rom_idx];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_pop) begin
            r_x_l <= i_in_left;
            r_x_r <= i_in_right;
        end
        if (r_state == slam_pkg::ST_WRAP) begin
            if (!r_ch) begin
                r_pbase <= r_prod[16 +: 39];
            end
            r_p <= w_pwrap;
        end
        if (r_state == slam_pkg::ST_LFO) begin
            r_a <= r_prod[16 +: A_W];
        end
        if (r_state == slam_pkg::ST_GAIN) begin
            r_g <= w_g33[17 +: LW];
        end
        if (r_state == slam_pkg::ST_SAT && !r_ch) begin
            r_res_l <= w_sat;
        end
    end

    assign o_out_left  = r_res_l;
    assign o_out_right = w_sat;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import slam_pkg::*;

    localparam int SW         = SAMPLE_BITS_DEF;
    localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;

    // Phase positions in Q.32 cycles
    localparam longint CYCLE     = 64'sd1 <<< 32;
    localparam longint LFO_CLAMP = 100 * CYCLE;

    // Sine series constants, Q2.30
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;

    localparam int STALL_MAX      = 18;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic signed [SW-1:0] t_sample;
    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_pair;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam t_slam_cfg CFG_RESET = '{
        input_gain:   23'd65536,
        output_gain:  23'd65536,
        waveform:     WAVE_SINE,
        mod_amount:   17'd65536,
        offset_left:  17'd0,
        offset_right: 17'd32768,
        width_recip:  23'd65536,
        phase_step:   32'd89478
    };

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    t_sample               i_left_sample  = '0;
    t_sample               i_right_sample = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    t_sample               o_left_result;
    t_sample               o_right_result;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    stereo_lfo_amplitude_modulator_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .empty          (empty),
        .pop            (pop),
        .o_left_result  (o_left_result),
        .o_right_result (o_right_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow of the block: register copy, LFO phase and the pairs still owed
    t_slam_cfg          model_cfg = CFG_RESET;
    logic [PHASE_W-1:0] lfo_acc   = '0;
    t_pair              pending_pairs[$];
    t_pair              popped_pair;

    int mismatches    = 0;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int rx_stall_left = 0;
    int rx_hold_left  = 0;
    int quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // round(2^16 * sin(pi/2 * r / quarter)) by a nested odd series in Q2.30
    function automatic longint quarter_sine(int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int          n;
        x  = (QUARTER_TURN_Q30 * (64'(r) << 2)) >> TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = UNIT_Q30;
        for (n = 5; n >= 1; n--) begin
            t = UNIT_Q30 - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
        end
        s = (x * t) >> 30;
        s = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return longint'(s);
    endfunction

    // table lookup by the top bits of the phase, folded by quadrant
    function automatic longint sine_lookup(longint p);
        int unsigned k;
        int unsigned quad;
        int unsigned r;
        longint      v;
        k    = int'(p >>> (32 - TABLE_BITS)) & ((1 << TABLE_BITS) - 1);
        quad = k >> (TABLE_BITS - 2);
        r    = k & ((1 << (TABLE_BITS - 2)) - 1);
        v    = quarter_sine((quad % 2 == 1) ? (1 << (TABLE_BITS - 2)) - r : r);
        return (quad >= 2) ? -v : v;
    endfunction

    // LFO value in Q.16 for one channel at the current phase
    function automatic longint lfo_shape(logic [AMT_W-1:0] offset);
        longint p;
        longint v32;
        p = (longint'(lfo_acc) * longint'(model_cfg.width_recip)) >>> 16;
        p = p + (longint'(offset) <<< 16);
        if (p > LFO_CLAMP) begin
            p = LFO_CLAMP;
        end
        // exactly one cycle is kept as it is
        if (p > CYCLE) begin
            p = p & (CYCLE - 1);
        end
        case (model_cfg.waveform)
            WAVE_SINE: begin
                return sine_lookup(p);
            end
            WAVE_TRIANGLE: begin
                if (p > 3 * (CYCLE / 4)) begin
                    v32 = 4 * (p - 3 * (CYCLE / 4)) - CYCLE;
                end else if (p > CYCLE / 4) begin
                    v32 = 2 * CYCLE - 4 * p;
                end else begin
                    v32 = 4 * p;
                end
            end
            WAVE_SQUARE:   v32 = (p < CYCLE / 2) ? -CYCLE : CYCLE;
            WAVE_SAW_UP:   v32 = 2 * p - CYCLE;
            WAVE_SAW_DOWN: v32 = CYCLE - 2 * p;
            default: begin
                return 0;
            end
        endcase
        return v32 >>> 16;
    endfunction

    // one channel: input level, LFO gain, output level, then clamp
    function automatic t_sample modulate_sample(t_sample x, logic [AMT_W-1:0] offset);
        longint amt;
        longint gain;
        longint a;
        longint b;
        longint c;
        amt  = longint'(model_cfg.mod_amount);
        gain = ((64'sd1 <<< 33) + lfo_shape(offset) * amt - amt * 65536) >>> 17;
        a    = (longint'(x) * longint'(model_cfg.input_gain)) >>> 16;
        b    = (a * gain) >>> 16;
        c    = (b * longint'(model_cfg.output_gain)) >>> 16;
        if (c > longint'(SAMPLE_MAX)) begin
            c = longint'(SAMPLE_MAX);
        end
        if (c < longint'(SAMPLE_MIN)) begin
            c = longint'(SAMPLE_MIN);
        end
        return c[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_sample random_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return t_sample'($urandom_range(255)) - t_sample'(128);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // an extreme, a value in range, or any bit pattern of the field
    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, int width);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            2:       return $urandom & ~({32{1'b1}} << width);
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic t_slam_cfg random_cfg();
        t_slam_cfg c;
        c.input_gain   = GAIN_W'(pick(1024, 4194304, GAIN_W));
        c.output_gain  = GAIN_W'(pick(1024, 4194304, GAIN_W));
        c.waveform     = WAVE_W'(pick(WAVE_SINE, WAVE_SAW_DOWN, WAVE_W));
        c.mod_amount   = AMT_W'(pick(0, 65536, AMT_W));
        c.offset_left  = AMT_W'(pick(0, 65536, AMT_W));
        c.offset_right = AMT_W'(pick(0, 65536, AMT_W));
        c.width_recip  = GAIN_W'(pick(32933, 6553600, GAIN_W));
        c.phase_step   = pick(0, 32'hFFFF_FFFF, PHASE_W);
        return c;
    endfunction

    // junk above the field width must be dropped by the block
    function automatic logic [CFG_DATA_W-1:0] pad_junk(logic [CFG_DATA_W-1:0] value,
                                                        int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = ~({CFG_DATA_W{1'b1}} << width);
        return ($urandom_range(1) == 1) ? (($urandom & ~mask) | value) : value;
    endfunction

    // one input beat; the expected pair is worked out at acceptance
    task automatic send_pair(t_sample left, t_sample right);
        t_pair due;
        push           <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        do @(posedge i_clk); while (full);
        due.left  = modulate_sample(left, model_cfg.offset_left);
        due.right = modulate_sample(right, model_cfg.offset_right);
        pending_pairs.push_back(due);
        lfo_acc = lfo_acc + model_cfg.phase_step;
    endtask

    // stop offering and wait until every owed pair is back
    task automatic wait_for_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_pairs.size() != 0);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_INPUT_GAIN:  model_cfg.input_gain   = data[GAIN_W-1:0];
            CFG_OUTPUT_GAIN: model_cfg.output_gain  = data[GAIN_W-1:0];
            CFG_WAVEFORM:    model_cfg.waveform     = data[WAVE_W-1:0];
            CFG_MOD_AMOUNT:  model_cfg.mod_amount   = data[AMT_W-1:0];
            CFG_OFFSET_L:    model_cfg.offset_left  = data[AMT_W-1:0];
            CFG_OFFSET_R:    model_cfg.offset_right = data[AMT_W-1:0];
            CFG_WIDTH_RECIP: model_cfg.width_recip  = data[GAIN_W-1:0];
            CFG_PHASE_STEP:  model_cfg.phase_step   = data[PHASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(t_slam_cfg c);
        wait_for_results();
        write_reg(CFG_INPUT_GAIN,  pad_junk(c.input_gain, GAIN_W));
        write_reg(CFG_OUTPUT_GAIN, pad_junk(c.output_gain, GAIN_W));
        write_reg(CFG_WAVEFORM,    pad_junk(c.waveform, WAVE_W));
        write_reg(CFG_MOD_AMOUNT,  pad_junk(c.mod_amount, AMT_W));
        write_reg(CFG_OFFSET_L,    pad_junk(c.offset_left, AMT_W));
        write_reg(CFG_OFFSET_R,    pad_junk(c.offset_right, AMT_W));
        write_reg(CFG_WIDTH_RECIP, pad_junk(c.width_recip, GAIN_W));
        write_reg(CFG_PHASE_STEP,  c.phase_step);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking and pop pacing
    // ------------------------------------------------------------------

    task automatic check_field(string what, t_sample want, t_sample got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s result mismatch, expected %0d, got %0d",
                         $time, what, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result beat with nothing owed (%0d, %0d)",
                             $time, o_left_result, o_right_result);
                end
            end else begin
                popped_pair = pending_pairs.pop_front();
                check_field("left", popped_pair.left, o_left_result);
                check_field("right", popped_pair.right, o_right_result);
            end
        end

        // long hold on request, otherwise random stall bursts
        if (holds_served != hold_requests) begin
            holds_served++;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            pop <= 1'b0;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            rx_stall_left = $urandom_range(STALL_MAX, 1) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset register values, sample extremes
    task automatic test_reset_values();
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair('0, -t_sample'(1));
        send_pair(t_sample'(1), '0);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
    endtask

    // every waveform code, unused ones too; phase fixed by the offsets alone
    task automatic test_every_waveform();
        t_slam_cfg c;
        int        code;
        for (code = 0; code < (1 << WAVE_W); code++) begin
            c              = CFG_RESET;
            c.waveform     = code[WAVE_W-1:0];
            c.width_recip  = '0;
            c.offset_left  = AMT_W'($urandom_range(65536, 0));
            c.offset_right = AMT_W'($urandom_range(65536, 0));
            set_config(c);
            send_pair(t_sample'($urandom), t_sample'($urandom));
        end
    endtask

    task automatic test_corner_cases();
        t_slam_cfg                c;
        logic [CFG_IDX_W-1:0]     stray;

        // left phase lands on exactly one cycle
        c              = CFG_RESET;
        c.waveform     = WAVE_TRIANGLE;
        c.width_recip  = '0;
        c.offset_left  = AMT_W'(65536);
        c.offset_right = '0;
        set_config(c);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);

        // second beat sees a stretched phase well past the LFO_CLAMP limit
        c              = CFG_RESET;
        c.waveform     = WAVE_SAW_UP;
        c.width_recip  = '1;
        c.offset_left  = '0;
        c.offset_right = '1;
        c.phase_step   = 32'hF000_0000 - lfo_acc;
        set_config(c);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);

        // depth above unity turns the gain negative
        c              = CFG_RESET;
        c.waveform     = WAVE_SQUARE;
        c.mod_amount   = '1;
        c.width_recip  = '0;
        c.offset_left  = '0;
        c.offset_right = AMT_W'(49152);
        set_config(c);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);

        // largest levels push both channels to the rails
        c             = CFG_RESET;
        c.input_gain  = '1;
        c.output_gain = '1;
        set_config(c);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);

        // writes past the register map must change nothing
        wait_for_results();
        stray = $urandom_range((1 << CFG_IDX_W) - 1, CFG_PHASE_STEP + 1);
        write_reg('1, $urandom);
        write_reg(stray, $urandom);
        i_cfg_valid <= 1'b0;
        send_pair(t_sample'($urandom), t_sample'($urandom));
    endtask

    // random settings, each held for a run of beats with its own idling
    task automatic test_random_settings();
        int phase;
        int n;
        for (phase = 0; phase < 15; phase++) begin
            tx_gap_pct   = 20 * $urandom_range(3);
            rx_stall_pct = 20 * $urandom_range(3);
            set_config(random_cfg());
            for (n = 0; n < 100; n++) begin
                send_pair(random_sample(), random_sample());
                if ($urandom_range(99) < tx_gap_pct) begin
                    push <= 1'b0;
                    repeat ($urandom_range(STALL_MAX, 1)) @(posedge i_clk);
                end
            end
        end
    endtask

    // receiver holds off while beats keep coming, so both queues fill
    task automatic test_full_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_requests++;
        repeat (30) send_pair(random_sample(), random_sample());
        wait_for_results();
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        set_config(random_cfg());
        repeat (150) send_pair(random_sample(), random_sample());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_every_waveform();
        test_corner_cases();
        test_random_settings();
        test_full_backpressure();
        test_steady_stream();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
design/slam_pkg.sv
design/slam_fifo.sv
design/slam_front.sv
design/slam_back.sv
design/stereo_lfo_amplitude_modulator_core.sv
verif/tb.sv
